// ===== rtl/core/cfx_pkg.sv =====
// ----------------------------------------------------------------------------
// cfx_pkg
// Shared types and opcode names for the complex fixed-point arithmetic unit.
// ----------------------------------------------------------------------------
package cfx_pkg;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_DIV   = 4'd3,
        OP_GT    = 4'd4,
        OP_EQ    = 4'd5,
        OP_NE    = 4'd6,
        OP_LT    = 4'd7,
        OP_GE    = 4'd8,
        OP_LE    = 4'd9,
        OP_SQMAG = 4'd10
    } t_op;

    // per-item control carried along the divider chain
    typedef struct packed {
        logic        vld;
        logic [3:0]  op;
        logic        dz;
        logic        cmp;
        logic        neg_re;
        logic        neg_im;
        logic [31:0] raw_re;
        logic [31:0] raw_im;
    } t_ctl;

endpackage

// ===== rtl/core/cfx_div_cell.sv =====
// ----------------------------------------------------------------------------
// cfx_div_cell
// One restoring-division step for both quotient lanes; one cell per quotient
// bit, registered toward the next cell.
// ----------------------------------------------------------------------------
module cfx_div_cell
    import cfx_pkg::*;
#(
    parameter int QW = 49,
    parameter int DW = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ctl          i_ctl,
    input  logic [DW-1:0] i_den,
    input  logic [DW:0]   i_rem_re,
    input  logic [DW:0]   i_rem_im,
    input  logic [QW-1:0] i_num_re,
    input  logic [QW-1:0] i_num_im,
    input  logic [QW-1:0] i_q_re,
    input  logic [QW-1:0] i_q_im,
    output t_ctl          o_ctl,
    output logic [DW-1:0] o_den,
    output logic [DW:0]   o_rem_re,
    output logic [DW:0]   o_rem_im,
    output logic [QW-1:0] o_num_re,
    output logic [QW-1:0] o_num_im,
    output logic [QW-1:0] o_q_re,
    output logic [QW-1:0] o_q_im
);

    logic [DW:0] n_sh_re, n_sh_im;
    logic [DW:0] n_rem_re, n_rem_im;
    logic        n_bit_re, n_bit_im;

    always_comb begin
        n_sh_re  = {i_rem_re[DW-1:0], i_num_re[QW-1]};
        n_sh_im  = {i_rem_im[DW-1:0], i_num_im[QW-1]};
        n_bit_re = n_sh_re >= {1'b0, i_den};
        n_bit_im = n_sh_im >= {1'b0, i_den};
        n_rem_re = n_bit_re ? n_sh_re - {1'b0, i_den} : n_sh_re;
        n_rem_im = n_bit_im ? n_sh_im - {1'b0, i_den} : n_sh_im;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.vld <= 1'b0;
        end else begin
            o_ctl.vld <= i_ctl.vld;
        end
        o_ctl.op     <= i_ctl.op;
        o_ctl.dz     <= i_ctl.dz;
        o_ctl.cmp    <= i_ctl.cmp;
        o_ctl.neg_re <= i_ctl.neg_re;
        o_ctl.neg_im <= i_ctl.neg_im;
        o_ctl.raw_re <= i_ctl.raw_re;
        o_ctl.raw_im <= i_ctl.raw_im;
        o_den        <= i_den;
        o_rem_re     <= n_rem_re;
        o_rem_im     <= n_rem_im;
        o_num_re     <= {i_num_re[QW-2:0], 1'b0};
        o_num_im     <= {i_num_im[QW-2:0], 1'b0};
        o_q_re       <= {i_q_re[QW-2:0], n_bit_re};
        o_q_im       <= {i_q_im[QW-2:0], n_bit_im};
    end

endmodule

// ===== rtl/core/complex_fixed_point_alu.sv =====
// ----------------------------------------------------------------------------
// complex_fixed_point_alu
// Complex Q16.16 add, sub, mul, div, squared magnitude and compares.
// ----------------------------------------------------------------------------
//  channel  | handshake         | ports
//  operands | i_start, o_busy   | i_opcode, i_a_re, i_a_im, i_b_re, i_b_im
//  result   | o_strobe (1 cyc)  | o_res_re, o_res_im, o_cmp_true,
//           |                   | o_div_by_zero, o_saturated
//
//  one transfer per cycle; every opcode passes stages 1 to 3, the chain of
//  division cells (one quotient bit per cell) and the output register.
//  o_busy is held low; results leave in transfer order.
//  synchronous active-low reset clears all valid bits of the pipeline.
// ----------------------------------------------------------------------------
module complex_fixed_point_alu
    import cfx_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [3:0]  i_opcode,
    input  logic signed [31:0] i_a_re,
    input  logic signed [31:0] i_a_im,
    input  logic signed [31:0] i_b_re,
    input  logic signed [31:0] i_b_im,
    output logic        o_strobe,
    output logic signed [31:0] o_res_re,
    output logic signed [31:0] o_res_im,
    output logic        o_cmp_true,
    output logic        o_div_by_zero,
    output logic        o_saturated
);

    // numerator magnitude <= 2^63, shifted by FRAC_BITS
    localparam int QW = 64 + FRAC_BITS;
    localparam int DW = 64;
    localparam int NC = QW;

    // stage 1: magnitudes and products
    logic        r1_vld;
    logic [3:0]  r1_op;
    logic        r1_cmp;
    logic [31:0] r1_bre, r1_bim;
    logic signed [31:0] r1_sre, r1_sim;
    logic        r1_sov_re, r1_sov_im;
    logic [63:0] r1_p_rr, r1_p_ii, r1_p_ri, r1_p_ir, r1_d_r, r1_d_i;
    logic        r1_n_rr, r1_n_ii, r1_n_ri, r1_n_ir;

    logic [31:0] n_mar, n_mai, n_mbr, n_mbi;
    logic        n_gt, n_lt, n_eq, n_cmp;
    logic [32:0] n_s_re, n_s_im;
    logic [31:0] n_m1a, n_m1b, n_m2a, n_m2b, n_m3a, n_m3b, n_m4a, n_m4b;

    always_comb begin
        n_mar = i_a_re[31] ? 32'(-i_a_re) : i_a_re;
        n_mai = i_a_im[31] ? 32'(-i_a_im) : i_a_im;
        n_mbr = i_b_re[31] ? 32'(-i_b_re) : i_b_re;
        n_mbi = i_b_im[31] ? 32'(-i_b_im) : i_b_im;
        n_eq  = (i_a_re == i_b_re) && (i_a_im == i_b_im);
        n_gt  = (i_a_re > i_b_re) || ((i_a_re == i_b_re) && (i_a_im > i_b_im));
        n_lt  = (i_a_re < i_b_re) || ((i_a_re == i_b_re) && (i_a_im < i_b_im));
        case (i_opcode)
            OP_GT:   n_cmp = n_gt;
            OP_EQ:   n_cmp = n_eq;
            OP_NE:   n_cmp = !n_eq;
            OP_LT:   n_cmp = n_lt;
            OP_GE:   n_cmp = !n_lt;
            OP_LE:   n_cmp = !n_gt;
            default: n_cmp = 1'b0;
        endcase
        if (i_opcode == OP_SUB) begin
            n_s_re = {i_a_re[31], i_a_re} - {i_b_re[31], i_b_re};
            n_s_im = {i_a_im[31], i_a_im} - {i_b_im[31], i_b_im};
        end else begin
            n_s_re = {i_a_re[31], i_a_re} + {i_b_re[31], i_b_re};
            n_s_im = {i_a_im[31], i_a_im} + {i_b_im[31], i_b_im};
        end
        // squared magnitude uses a*a, otherwise cross products
        n_m1a = n_mar;
        n_m1b = (i_opcode == OP_SQMAG) ? n_mar : n_mbr;
        n_m2a = n_mai;
        n_m2b = (i_opcode == OP_SQMAG) ? n_mai : n_mbi;
        n_m3a = n_mar;
        n_m3b = n_mbi;
        n_m4a = n_mai;
        n_m4b = n_mbr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_start;
        end
        r1_op     <= i_opcode;
        r1_cmp    <= n_cmp;
        r1_bre    <= i_b_re;
        r1_bim    <= i_b_im;
        r1_sre    <= n_s_re[31:0];
        r1_sim    <= n_s_im[31:0];
        r1_sov_re <= n_s_re[32] != n_s_re[31];
        r1_sov_im <= n_s_im[32] != n_s_im[31];
        r1_p_rr   <= n_m1a * n_m1b;
        r1_p_ii   <= n_m2a * n_m2b;
        r1_p_ri   <= n_m3a * n_m3b;
        r1_p_ir   <= n_m4a * n_m4b;
        r1_d_r    <= n_mbr * n_mbr;
        r1_d_i    <= n_mbi * n_mbi;
        r1_n_rr   <= i_a_re[31] ^ i_b_re[31];
        r1_n_ii   <= i_a_im[31] ^ i_b_im[31];
        r1_n_ri   <= i_a_re[31] ^ i_b_im[31];
        r1_n_ir   <= i_a_im[31] ^ i_b_re[31];
    end

    // stage 2: signed sums of products (65-bit two's complement)
    logic        r2_vld;
    logic [3:0]  r2_op;
    logic        r2_cmp;
    logic [31:0] r2_bre, r2_bim;
    logic signed [31:0] r2_sre, r2_sim;
    logic        r2_sov_re, r2_sov_im;
    logic signed [64:0] r2_x_re, r2_x_im;
    logic [64:0] r2_den;

    logic signed [64:0] n_prr, n_pii, n_pri, n_pir;

    always_comb begin
        n_prr = (r1_n_rr && r1_op != OP_SQMAG) ? -$signed({1'b0, r1_p_rr})
                                               : $signed({1'b0, r1_p_rr});
        n_pii = (r1_n_ii && r1_op != OP_SQMAG) ? -$signed({1'b0, r1_p_ii})
                                               : $signed({1'b0, r1_p_ii});
        n_pri = r1_n_ri ? -$signed({1'b0, r1_p_ri}) : $signed({1'b0, r1_p_ri});
        n_pir = r1_n_ir ? -$signed({1'b0, r1_p_ir}) : $signed({1'b0, r1_p_ir});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_op     <= r1_op;
        r2_cmp    <= r1_cmp;
        r2_bre    <= r1_bre;
        r2_bim    <= r1_bim;
        r2_sre    <= r1_sre;
        r2_sim    <= r1_sim;
        r2_sov_re <= r1_sov_re;
        r2_sov_im <= r1_sov_im;
        r2_den    <= {1'b0, r1_d_r} + {1'b0, r1_d_i};
        case (r1_op)
            OP_DIV: begin
                r2_x_re <= n_prr + n_pii;
                r2_x_im <= n_pir - n_pri;
            end
            OP_MUL: begin
                r2_x_re <= n_prr - n_pii;
                r2_x_im <= n_pri + n_pir;
            end
            default: begin
                r2_x_re <= n_prr + n_pii;
                r2_x_im <= '0;
            end
        endcase
    end

    // stage 3: sign/magnitude split and chain entry
    t_ctl        c_ctl [NC+1];
    logic [DW-1:0] c_den [NC+1];
    logic [DW:0]   c_rre [NC+1];
    logic [DW:0]   c_rim [NC+1];
    logic [QW-1:0] c_nre [NC+1];
    logic [QW-1:0] c_nim [NC+1];
    logic [QW-1:0] c_qre [NC+1];
    logic [QW-1:0] c_qim [NC+1];

    t_ctl          r3_ctl;
    logic [DW-1:0] r3_den;
    logic [QW-1:0] r3_nre, r3_nim;

    logic [63:0] n_mre, n_mim;
    logic        n_dz;
    logic        n_addsub;

    always_comb begin
        n_mre    = r2_x_re[64] ? 64'(-r2_x_re) : r2_x_re[63:0];
        n_mim    = r2_x_im[64] ? 64'(-r2_x_im) : r2_x_im[63:0];
        n_dz     = (r2_op == OP_DIV) && (r2_den == '0);
        n_addsub = (r2_op == OP_ADD) || (r2_op == OP_SUB);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl.vld <= 1'b0;
        end else begin
            r3_ctl.vld <= r2_vld;
        end
        r3_ctl.op     <= r2_op;
        r3_ctl.dz     <= n_dz;
        r3_ctl.cmp    <= r2_cmp;
        // add and sub carry the overflow flag in the sign bits
        r3_ctl.neg_re <= n_addsub ? r2_sov_re : r2_x_re[64];
        r3_ctl.neg_im <= n_addsub ? r2_sov_im : r2_x_im[64];
        case (r2_op)
            OP_ADD, OP_SUB: begin
                r3_ctl.raw_re <= r2_sre;
                r3_ctl.raw_im <= r2_sim;
            end
            OP_DIV: begin
                r3_ctl.raw_re <= r2_bre;
                r3_ctl.raw_im <= r2_bim;
            end
            default: begin
                r3_ctl.raw_re <= '0;
                r3_ctl.raw_im <= '0;
            end
        endcase
        r3_den <= (n_dz || r2_op != OP_DIV) ? 64'd1 : r2_den[63:0];
        r3_nre <= {n_mre, {(QW-64){1'b0}}};
        r3_nim <= {n_mim, {(QW-64){1'b0}}};
    end

    assign c_ctl[0] = r3_ctl;
    assign c_den[0] = r3_den;
    assign c_rre[0] = '0;
    assign c_rim[0] = '0;
    assign c_nre[0] = r3_nre;
    assign c_nim[0] = r3_nim;
    assign c_qre[0] = '0;
    assign c_qim[0] = '0;

    for (genvar g = 0; g < NC; g++) begin : g_cell
        cfx_div_cell #(
            .QW(QW),
            .DW(DW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (c_ctl[g]),
            .i_den   (c_den[g]),
            .i_rem_re(c_rre[g]),
            .i_rem_im(c_rim[g]),
            .i_num_re(c_nre[g]),
            .i_num_im(c_nim[g]),
            .i_q_re  (c_qre[g]),
            .i_q_im  (c_qim[g]),
            .o_ctl   (c_ctl[g+1]),
            .o_den   (c_den[g+1]),
            .o_rem_re(c_rre[g+1]),
            .o_rem_im(c_rim[g+1]),
            .o_num_re(c_nre[g+1]),
            .o_num_im(c_nim[g+1]),
            .o_q_re  (c_qre[g+1]),
            .o_q_im  (c_qim[g+1])
        );
    end

    // output stage: clip and select
    t_ctl        e_ctl;
    logic [QW-1:0] e_qre, e_qim;
    logic [31:0] n_ore, n_oim;
    logic        n_sre, n_sim;
    logic [31:0] n_dre, n_dim;
    logic        n_dsre, n_dsim;
    logic [31:0] n_mwre, n_mwim;
    logic        n_msre, n_msim;

    assign e_ctl = c_ctl[NC];
    assign e_qre = c_qre[NC];
    assign e_qim = c_qim[NC];

    function automatic logic [32:0] clip_sm(input logic neg, input logic [QW-1:0] m);
        logic [32:0] r;
        if (!neg || m == '0) begin
            r = (m > QW'(32'h7FFF_FFFF)) ? {1'b1, 32'h7FFF_FFFF} : {1'b0, m[31:0]};
        end else begin
            r = (m > QW'(33'h8000_0000)) ? {1'b1, 32'h8000_0000}
                                         : {1'b0, 32'(-m[31:0])};
        end
        return r;
    endfunction

    always_comb begin
        {n_dsre, n_dre} = clip_sm(e_ctl.neg_re, e_qre);
        {n_dsim, n_dim} = clip_sm(e_ctl.neg_im, e_qim);
        // mul and sqmag: quotient by 1 of the shifted value, then drop the fraction
        {n_msre, n_mwre} = clip_sm(e_ctl.neg_re, e_qre >> (2 * FRAC_BITS));
        {n_msim, n_mwim} = clip_sm(e_ctl.neg_im, e_qim >> (2 * FRAC_BITS));
        n_ore = '0;
        n_oim = '0;
        n_sre = 1'b0;
        n_sim = 1'b0;
        case (e_ctl.op)
            OP_ADD, OP_SUB: begin
                n_sre = e_ctl.neg_re;
                n_sim = e_ctl.neg_im;
                n_ore = e_ctl.neg_re ? (e_ctl.raw_re[31] ? 32'h7FFF_FFFF : 32'h8000_0000)
                                     : e_ctl.raw_re;
                n_oim = e_ctl.neg_im ? (e_ctl.raw_im[31] ? 32'h7FFF_FFFF : 32'h8000_0000)
                                     : e_ctl.raw_im;
            end
            OP_DIV: begin
                if (e_ctl.dz) begin
                    n_ore = e_ctl.raw_re;
                    n_oim = e_ctl.raw_im;
                end else begin
                    n_ore = n_dre;
                    n_oim = n_dim;
                    n_sre = n_dsre;
                    n_sim = n_dsim;
                end
            end
            OP_MUL, OP_SQMAG: begin
                n_ore = n_mwre;
                n_oim = n_mwim;
                n_sre = n_msre;
                n_sim = n_msim;
            end
            default: begin
                n_ore = '0;
            end
        endcase
    end

    logic        r_strobe;
    logic [31:0] r_res_re, r_res_im;
    logic        r_cmp, r_dz, r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= e_ctl.vld;
        end
        r_res_re <= n_ore;
        r_res_im <= n_oim;
        r_cmp    <= e_ctl.cmp;
        r_dz     <= e_ctl.dz;
        r_sat    <= n_sre | n_sim;
    end

    assign o_busy        = 1'b0;
    assign o_strobe      = r_strobe;
    assign o_res_re      = r_res_re;
    assign o_res_im      = r_res_im;
    assign o_cmp_true    = r_cmp;
    assign o_div_by_zero = r_dz;
    assign o_saturated   = r_sat;

    a_dz_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_div_by_zero |-> !o_saturated && !o_cmp_true)
        else $error("divide by zero with other flags");
    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_cmp_true |-> o_res_re == '0 && o_res_im == '0)
        else $error("compare result with nonzero data");
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("strobe right after reset");

endmodule

// ===== tb/sv/cfx_result_checker.sv =====
// ----------------------------------------------------------------------------
// cfx_result_checker
// Watches the operand and result channels of the complex fixed-point unit,
// computes the expected result of every accepted operand transfer and
// compares each result strobe field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module cfx_result_checker
    import cfx_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [3:0]         i_opcode,
    input  logic signed [31:0] i_a_re,
    input  logic signed [31:0] i_a_im,
    input  logic signed [31:0] i_b_re,
    input  logic signed [31:0] i_b_im,
    input  logic               i_strobe,
    input  logic signed [31:0] i_res_re,
    input  logic signed [31:0] i_res_im,
    input  logic               i_cmp_true,
    input  logic               i_div_by_zero,
    input  logic               i_saturated,
    output int                 o_pending,
    output int                 o_errors
);

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               cmp;
        logic               dz;
        logic               sat;
    } t_cfx_result;

    t_cfx_result expected_q[$];
    int          mismatches = 0;

    assign o_pending = expected_q.size();
    assign o_errors  = mismatches;

    function automatic logic signed [31:0] clip_q16(input logic signed [127:0] v,
                                                    inout logic sat);
        if (v > 128'sh7fffffff) begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -128'sh80000000) begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_cfx_result cfx_compute(input logic [3:0] op,
                                                input logic signed [31:0] ar,
                                                input logic signed [31:0] ai,
                                                input logic signed [31:0] br,
                                                input logic signed [31:0] bi);
        logic signed [127:0] xr, xi, yr, yi, den, scale;
        logic                gt, lt, eq;
        t_cfx_result         r;
        xr    = ar;
        xi    = ai;
        yr    = br;
        yi    = bi;
        scale = 128'sd1 <<< FRAC_BITS;
        gt    = (ar > br) || (ar == br && ai > bi);
        lt    = (ar < br) || (ar == br && ai < bi);
        eq    = (ar == br) && (ai == bi);
        r     = '{re: '0, im: '0, cmp: 1'b0, dz: 1'b0, sat: 1'b0};
        case (t_op'(op))
            OP_ADD: begin
                r.re = clip_q16(xr + yr, r.sat);
                r.im = clip_q16(xi + yi, r.sat);
            end
            OP_SUB: begin
                r.re = clip_q16(xr - yr, r.sat);
                r.im = clip_q16(xi - yi, r.sat);
            end
            OP_MUL: begin
                r.re = clip_q16((xr * yr - xi * yi) / scale, r.sat);
                r.im = clip_q16((xr * yi + xi * yr) / scale, r.sat);
            end
            OP_DIV: begin
                den = yr * yr + yi * yi;
                if (den == 0) begin
                    r.re = br;
                    r.im = bi;
                    r.dz = 1'b1;
                end else begin
                    r.re = clip_q16(((xr * yr + xi * yi) * scale) / den, r.sat);
                    r.im = clip_q16(((xi * yr - xr * yi) * scale) / den, r.sat);
                end
            end
            OP_GT:    r.cmp = gt;
            OP_EQ:    r.cmp = eq;
            OP_NE:    r.cmp = !eq;
            OP_LT:    r.cmp = lt;
            OP_GE:    r.cmp = !lt;
            OP_LE:    r.cmp = !gt;
            OP_SQMAG: r.re = clip_q16((xr * xr + xi * xi) / scale, r.sat);
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_cfx_result want;
        if (i_rst_n && i_strobe) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                $display("%0t: result with no transfer waiting: re=%h im=%h", $time,
                         i_res_re, i_res_im);
            end else begin
                want = expected_q.pop_front();
                if (i_res_re !== want.re) begin
                    mismatches++;
                    $display("%0t: res_re expected %h actual %h", $time, want.re, i_res_re);
                end
                if (i_res_im !== want.im) begin
                    mismatches++;
                    $display("%0t: res_im expected %h actual %h", $time, want.im, i_res_im);
                end
                if (i_cmp_true !== want.cmp) begin
                    mismatches++;
                    $display("%0t: cmp_true expected %b actual %b", $time, want.cmp,
                             i_cmp_true);
                end
                if (i_div_by_zero !== want.dz) begin
                    mismatches++;
                    $display("%0t: div_by_zero expected %b actual %b", $time, want.dz,
                             i_div_by_zero);
                end
                if (i_saturated !== want.sat) begin
                    mismatches++;
                    $display("%0t: saturated expected %b actual %b", $time, want.sat,
                             i_saturated);
                end
            end
        end
        if (i_rst_n && i_start && !i_busy)
            expected_q.push_back(cfx_compute(i_opcode, i_a_re, i_a_im, i_b_re, i_b_im));
    end

endmodule

// ===== tb/sv/tb_complex_fixed_point_alu.sv =====
// ----------------------------------------------------------------------------
// tb_complex_fixed_point_alu
// Drives directed and random operand transfers into the complex fixed-point
// unit with varying sender gaps; a checker beside the block predicts and
// compares every result, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_complex_fixed_point_alu;
    import cfx_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int LATENCY   = 4 + 64 + FRAC_BITS;
    localparam int LIMIT     = 400000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic [3:0]         i_opcode = '0;
    logic signed [31:0] i_a_re = '0;
    logic signed [31:0] i_a_im = '0;
    logic signed [31:0] i_b_re = '0;
    logic signed [31:0] i_b_im = '0;
    logic               o_strobe;
    logic signed [31:0] o_res_re;
    logic signed [31:0] o_res_im;
    logic               o_cmp_true;
    logic               o_div_by_zero;
    logic               o_saturated;
    int                 pending;
    int                 errors;
    int                 cycles = 0;

    always #6 i_clk = ~i_clk;

    complex_fixed_point_alu #(.FRAC_BITS(FRAC_BITS)) u_dut (.*);

    cfx_result_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_opcode,
        .i_a_re, .i_a_im, .i_b_re, .i_b_im,
        .i_strobe(o_strobe), .i_res_re(o_res_re), .i_res_im(o_res_im),
        .i_cmp_true(o_cmp_true), .i_div_by_zero(o_div_by_zero),
        .i_saturated(o_saturated), .o_pending(pending), .o_errors(errors)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return '0;
            3:       return $urandom_range(0, 1) ? 32'sh00010000 : -32'sh00010000;
            4, 5:    return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            6:       return $signed($urandom_range(0, 32'h3ff)) - 32'sh200;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_op(input logic [3:0] op, input logic signed [31:0] ar,
                           input logic signed [31:0] ai, input logic signed [31:0] br,
                           input logic signed [31:0] bi);
        @(negedge i_clk);
        i_start  = 1'b1;
        i_opcode = op;
        i_a_re   = ar;
        i_a_im   = ai;
        i_b_re   = br;
        i_b_im   = bi;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic idle_cycle();
        @(negedge i_clk);
        i_start = 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_phase(input int count, input int gap_pct);
        logic signed [31:0] ar, ai, br, bi;
        logic [3:0]         op;
        for (int n = 0; n < count; n++) begin
            while ($urandom_range(0, 99) < gap_pct) idle_cycle();
            op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                              : 4'($urandom_range(OP_ADD, OP_SQMAG));
            ar = pick_operand();
            ai = pick_operand();
            br = pick_operand();
            bi = pick_operand();
            case ($urandom_range(0, 9))
                0: begin
                    br = ar;
                    bi = ai;
                end
                1: br = ar;
                2: if (op == OP_DIV) begin
                    br = '0;
                    bi = '0;
                end
                default: ;
            endcase
            send_op(op, ar, ai, br, bi);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes of every opcode
        for (int op = OP_ADD; op <= OP_SQMAG; op++)
            send_op(4'(op), 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
        send_op(OP_ADD, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_op(OP_MUL, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_op(OP_DIV, 32'sh00030000, -32'sh00020000, '0, '0);
        send_op(OP_DIV, 32'sh7fffffff, 32'sh7fffffff, 32'sh00000001, '0);
        send_op(OP_DIV, -32'sh00070000, 32'sh00010000, 32'sh00020000, -32'sh00030000);
        send_op(OP_EQ, 32'sh00012345, -32'sh1, 32'sh00012345, -32'sh1);
        send_op(OP_GE, 32'sh00012345, -32'sh1, 32'sh00012345, -32'sh1);
        send_op(OP_LE, 32'sh00012345, -32'sh1, 32'sh00012345, -32'sh1);
        send_op(OP_LT, 32'sh5, 32'sh3, 32'sh5, 32'sh4);
        send_op(OP_GT, 32'sh5, 32'sh3, 32'sh5, 32'sh4);
        send_op(OP_SQMAG, 32'sh80000000, 32'sh80000000, '0, '0);
        send_op(4'd11, 32'sh1, 32'sh1, 32'sh1, 32'sh1);
        send_op(4'd15, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);

        random_phase(400, 11);
        @(negedge i_clk);
        i_start = 1'b0;
        while (pending != 0) @(posedge i_clk);
        random_phase(400, 65);
        random_phase(400, 0);

        @(negedge i_clk);
        i_start = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
